### rtl/core/scale_quantizer_31_step_core_assert.svh
// ----------------------------------------------------------------------------
// scale_quantizer_31_step_core assertion macros
// shared assertion forms, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCALE_QUANTIZER_31_STEP_CORE_ASSERT_SVH
`define SCALE_QUANTIZER_31_STEP_CORE_ASSERT_SVH

// condition holds in the same cycle
`define SQ31_ASSERT_COMB(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition holds in the following cycle
`define SQ31_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/sq31_pkg.sv
// ----------------------------------------------------------------------------
// sq31_pkg
// shared types and constants of the 31-step pitch quantizer
// ----------------------------------------------------------------------------
`default_nettype none

package sq31_pkg;

    localparam int STEPS      = 31;
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 21;
    localparam int CH_W       = 4;
    localparam int PITCH_W    = 10;
    localparam int NOTE_W     = 7;
    localparam int CNT_W      = $clog2(STEPS + 1);
    localparam int POS_W      = $clog2(STEPS);
    localparam int PULSE_W    = 16;
    localparam int RMODE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [STEPS-1:0]   MASK_RESET  = 31'h1084_2421;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd48;

    typedef enum logic [RMODE_W-1:0] {
        RND_DOWN    = 2'd0,
        RND_NEAREST = 2'd1,
        RND_UP      = 2'd2
    } t_round_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOTE_MASK   = 2'd0,
        REG_ROUND_MODE  = 2'd1,
        REG_EQUAL_SHARE = 2'd2,
        REG_PULSE_LEN   = 2'd3
    } t_cfg_reg;

    // derived view of the note mask
    typedef struct packed {
        logic [STEPS-1:0]            mask;
        logic [CNT_W-1:0]            count;
        logic [POS_W-1:0]            first;
        logic [POS_W-1:0]            last;
        logic [STEPS-1:0][CNT_W-1:0] rank;
    } t_mask_info;

    typedef struct packed {
        logic                      en;
        logic [CH_W-1:0]           ch;
        logic signed [PITCH_W-1:0] pitch;
    } t_trig_req;

endpackage

`default_nettype wire

### rtl/core/sq31_mask_info.sv
// ----------------------------------------------------------------------------
// sq31_mask_info
// registers step count, first and last enabled step and per-step rank
// ----------------------------------------------------------------------------
`default_nettype none

module sq31_mask_info
    import sq31_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [STEPS-1:0] i_mask,
    output t_mask_info            o_info
);

    logic [STEPS-1:0] eff_mask;
    t_mask_info       n_info;
    t_mask_info       r_info;

    always_comb begin
        // empty mask means root only
        eff_mask     = (i_mask == '0) ? STEPS'(1) : i_mask;
        n_info       = '0;
        n_info.mask  = eff_mask;
        n_info.count = CNT_W'($countones(eff_mask));
        for (int i = STEPS - 1; i >= 0; i--) begin
            if (eff_mask[i]) begin
                n_info.first = POS_W'(i);
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            if (eff_mask[i]) begin
                n_info.last = POS_W'(i);
            end
        end
        // number of enabled steps below step i
        for (int i = 0; i < STEPS; i++) begin
            n_info.rank[i] = CNT_W'($countones(eff_mask & ((STEPS'(1) << i) - STEPS'(1))));
        end
    end

    always_ff @(posedge i_clk) begin
        r_info <= n_info;
    end

    assign o_info = r_info;

endmodule

`default_nettype wire

### rtl/core/sq31_trigger.sv
// ----------------------------------------------------------------------------
// sq31_trigger
// per-channel last pitch and pulse counter, raises trigger while a pulse from a pitch change lasts
// ----------------------------------------------------------------------------
`default_nettype none

module sq31_trigger
    import sq31_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_trig_req          i_req,
    input  wire logic [PULSE_W-1:0] i_pulse_len,
    output logic                    o_trigger
);

    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [PITCH_W-1:0] r_last_pitch [CHANNELS];
    logic [PULSE_W-1:0]        r_pulse_left [CHANNELS];

    logic               ch_ok;
    logic [CIW-1:0]     ch_idx;
    logic               changed;
    logic [PULSE_W-1:0] left_now;
    logic [PULSE_W-1:0] left_set;
    logic [PULSE_W-1:0] n_left;

    always_comb begin
        ch_ok    = ({1'b0, i_req.ch} < (CH_W + 1)'(CHANNELS));
        ch_idx   = i_req.ch[CIW-1:0];
        changed  = (i_req.pitch != r_last_pitch[ch_idx]);
        left_now = r_pulse_left[ch_idx];
        // a change stretches the pulse to at least pulse_len
        left_set = (changed && (left_now < i_pulse_len)) ? i_pulse_len : left_now;
        n_left   = (left_set != '0) ? (left_set - PULSE_W'(1)) : '0;
    end

    assign o_trigger = ch_ok && (left_set != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_last_pitch[k] <= '0;
                r_pulse_left[k] <= '0;
            end
        end else if (i_req.en && ch_ok) begin
            r_last_pitch[ch_idx] <= i_req.pitch;
            r_pulse_left[ch_idx] <= n_left;
        end
    end

endmodule

`default_nettype wire

### rtl/core/scale_quantizer_31_step_core.sv
// ----------------------------------------------------------------------------
// scale_quantizer_31_step_core
// pitch quantizer to a 31-step octave with per-channel change trigger
// throughput: one request per cycle while the result side is ready, through an 8-register pipeline
// reset: synchronous active low; config returns to defaults, channel state
// clears, and requests wait for r_run, which sets on the first clock after reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "scale_quantizer_31_step_core_assert.svh"

module scale_quantizer_31_step_core
    import sq31_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [47:0]           i_s_tdata,   // cv_in[20:0], root_cv[41:21], zero pad
    input  wire logic [CH_W-1:0]       i_s_tuser,   // channel
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [15:0]                o_m_tdata,   // pitch_steps[9:0], trigger[10], zero pad
    output logic [CH_W-1:0]            o_m_tuser,   // out_channel
    // configuration writes
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NSTG        = 8;
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + STEPS - 1) / STEPS;
    localparam int OCT_BIAS    = (1 << (IN_W - 1 - FRAC_BITS)) + 1;
    localparam int Y_BIAS      = OCT_BIAS * STEPS;
    localparam int SPAN        = STEPS << FRAC_BITS;
    localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

    // floor(v / STEPS) for v below 1024
    function automatic logic [5:0] div_steps(input logic [9:0] v);
        logic [20:0] prod;
        prod = {11'b0, v} * 21'(RECIP);
        return prod[20:15];
    endfunction

    // configuration
    logic [STEPS-1:0]   r_note_mask;
    logic [RMODE_W-1:0] r_round_mode;
    logic               r_equal_share;
    logic [PULSE_W-1:0] r_pulse_len;
    logic               r_run;

    t_mask_info mi;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_rdy;

    // stage payloads
    logic [CH_W-1:0]          r_s0_ch;
    logic signed [IN_W-1:0]   r_s0_cv;
    logic [IN_W-1:0]          r_s0_root;

    logic [CH_W-1:0]          r_s1_ch;
    logic [9:0]               r_s1_y;
    logic [FRAC_BITS-1:0]     r_s1_frac;
    logic [4:0]               r_s1_r;

    logic [CH_W-1:0]          r_s2_ch;
    logic [5:0]               r_s2_q;
    logic [POS_W-1:0]         r_s2_n;
    logic [FRAC_BITS-1:0]     r_s2_frac;
    logic [4:0]               r_s2_r;

    logic [CH_W-1:0]          r_s3_ch;
    logic [5:0]               r_s3_q;
    logic [4:0]               r_s3_r;
    logic signed [NOTE_W-1:0] r_s3_note;
    logic [25:0]              r_s3_nf;

    logic [CH_W-1:0]          r_s4_ch;
    logic [5:0]               r_s4_q;
    logic [4:0]               r_s4_r;
    logic signed [NOTE_W-1:0] r_s4_note;
    logic [9:0]               r_s4_v;

    logic [CH_W-1:0]          r_s5_ch;
    logic [5:0]               r_s5_q;
    logic [4:0]               r_s5_r;
    logic signed [NOTE_W-1:0] r_s5_note;
    logic [5:0]               r_s5_idx;

    logic [CH_W-1:0]           r_s6_ch;
    logic signed [PITCH_W-1:0] r_s6_pitch;

    logic [CH_W-1:0]           r_out_ch;
    logic signed [PITCH_W-1:0] r_out_pitch;
    logic                      r_out_trig;

    // stage 0 -> 1
    logic [20:0]        root_mul;
    logic [20:0]        root_sum;
    logic [4:0]         root_step;
    logic signed [26:0] cv_x;
    logic signed [26:0] cv31;
    logic signed [26:0] x_val;
    logic signed [11:0] y_wide;

    // stage 1 -> 2
    logic [5:0]  q_val;
    logic [10:0] q31_a;
    logic [10:0] n_diff;

    // stage 2 -> 3
    logic                     lo_found;
    logic                     up_found;
    logic [POS_W-1:0]         lo_pos;
    logic [POS_W-1:0]         up_pos;
    logic signed [NOTE_W-1:0] lo_step;
    logic signed [NOTE_W-1:0] up_step;
    logic signed [7:0]        lo8;
    logic signed [7:0]        up8;
    logic signed [7:0]        t_sum;
    logic signed [7:0]        thr2;
    logic signed [24:0]       f2_cmp;
    logic signed [24:0]       thr_cmp;
    logic signed [NOTE_W-1:0] note_norm;
    logic [25:0]              nf_val;

    // stage 3 -> 4
    logic [26:0] sum_up;
    logic [26:0] sum_nr;
    logic [9:0]  v_val;

    // stage 4 -> 5
    logic [5:0] idx_raw;
    logic [5:0] idx_val;

    // stage 5 -> 6
    logic signed [NOTE_W-1:0]  note_eq;
    logic signed [NOTE_W-1:0]  note_sel;
    logic [10:0]               q31_b;
    logic signed [11:0]        pitch_wide;
    logic signed [PITCH_W-1:0] pitch_sat;

    // stage 6 -> out
    t_trig_req trig_req;
    logic      trig_val;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_mask   <= MASK_RESET;
            r_round_mode  <= RND_NEAREST;
            r_equal_share <= 1'b0;
            r_pulse_len   <= PULSE_RESET;
            r_run         <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_NOTE_MASK:   r_note_mask   <= i_cfg_data[STEPS-1:0];
                    REG_ROUND_MODE:  r_round_mode  <= i_cfg_data[RMODE_W-1:0];
                    REG_EQUAL_SHARE: r_equal_share <= i_cfg_data[0];
                    REG_PULSE_LEN:   r_pulse_len   <= i_cfg_data[PULSE_W-1:0];
                endcase
            end
        end
    end

    sq31_mask_info u_mask_info (
        .i_clk  (i_clk),
        .i_mask (r_note_mask),
        .o_info (mi)
    );

    // ------------------------------------------------------------------------
    // pipeline handshake: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------------
    always_comb begin
        w_rdy[NSTG] = i_m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_s_tready = r_run && w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid && r_run;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    always_comb begin
        // root snapped to nearest step of its fraction of a volt
        root_mul  = {r_s0_root[FRAC_BITS-1:0], 5'b0} - {5'b0, r_s0_root[FRAC_BITS-1:0]};
        root_sum  = root_mul + 21'(1 << (FRAC_BITS - 1));
        root_step = root_sum[20:16];
        cv_x      = {{6{r_s0_cv[IN_W-1]}}, r_s0_cv};
        cv31      = (cv_x <<< 5) - cv_x;
        x_val     = cv31 - $signed({6'b0, root_step, 16'b0});
        // biased integer part, always non-negative
        y_wide    = $signed({x_val[26], x_val[26:16]}) + 12'(Y_BIAS);
    end

    always_comb begin
        q_val  = div_steps(r_s1_y);
        q31_a  = {q_val, 5'b0} - {5'b0, q_val};
        n_diff = {1'b0, r_s1_y} - q31_a;
    end

    always_comb begin
        lo_found = 1'b0;
        up_found = 1'b0;
        lo_pos   = '0;
        up_pos   = '0;
        for (int i = 0; i < STEPS; i++) begin
            if (mi.mask[i] && (POS_W'(i) <= r_s2_n)) begin
                lo_found = 1'b1;
                lo_pos   = POS_W'(i);
            end
        end
        for (int i = STEPS - 1; i >= 0; i--) begin
            if (mi.mask[i] && (POS_W'(i) > r_s2_n)) begin
                up_found = 1'b1;
                up_pos   = POS_W'(i);
            end
        end
        // neighbours wrap to the adjacent octave
        lo_step = lo_found ? $signed({2'b00, lo_pos})
                           : $signed({2'b00, mi.last}) - 7'sd31;
        up_step = up_found ? $signed({2'b00, up_pos})
                           : $signed({2'b00, mi.first}) + 7'sd31;
        lo8   = {lo_step[NOTE_W-1], lo_step};
        up8   = {up_step[NOTE_W-1], up_step};
        t_sum = lo8 + up8;
        case (r_round_mode)
            RND_DOWN: thr2 = (up8 <<< 1) - 8'sd1;
            RND_UP:   thr2 = (lo8 <<< 1) + 8'sd1;
            default:  thr2 = t_sum[0] ? t_sum : (t_sum + 8'sd1);
        endcase
        f2_cmp    = $signed({3'b0, r_s2_n, r_s2_frac, 1'b0});
        thr_cmp   = $signed({thr2[7], thr2, 16'b0});
        note_norm = (f2_cmp > thr_cmp) ? up_step : lo_step;
        nf_val    = 26'(mi.count) * 26'({r_s2_n, r_s2_frac});
    end

    always_comb begin
        sum_up = {1'b0, r_s3_nf} + 27'(SPAN - 1);
        sum_nr = {r_s3_nf, 1'b0} + 27'(SPAN);
        case (r_round_mode)
            RND_DOWN: v_val = r_s3_nf[25:16];
            RND_UP:   v_val = sum_up[25:16];
            default:  v_val = sum_nr[26:17];
        endcase
    end

    always_comb begin
        idx_raw = div_steps(r_s4_v);
        idx_val = (idx_raw > {1'b0, mi.count}) ? {1'b0, mi.count} : idx_raw;
    end

    always_comb begin
        note_eq = '0;
        if (r_s5_idx == {1'b0, mi.count}) begin
            note_eq = $signed({2'b00, mi.first}) + 7'sd31;
        end else begin
            for (int i = 0; i < STEPS; i++) begin
                if (mi.mask[i] && ({1'b0, mi.rank[i]} == r_s5_idx)) begin
                    note_eq = NOTE_W'(i);
                end
            end
        end
        note_sel   = r_equal_share ? note_eq : r_s5_note;
        q31_b      = {r_s5_q, 5'b0} - {5'b0, r_s5_q};
        pitch_wide = $signed({1'b0, q31_b}) - 12'(Y_BIAS)
                     + {{5{note_sel[NOTE_W-1]}}, note_sel}
                     + $signed({7'b0, r_s5_r});
        if (pitch_wide > 12'sd511) begin
            pitch_sat = 10'sd511;
        end else if (pitch_wide < -12'sd512) begin
            pitch_sat = -10'sd512;
        end else begin
            pitch_sat = pitch_wide[PITCH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_ch   <= i_s_tuser;
            r_s0_cv   <= i_s_tdata[20:0];
            r_s0_root <= i_s_tdata[41:21];
        end
        if (w_rdy[1]) begin
            r_s1_ch   <= r_s0_ch;
            r_s1_y    <= y_wide[9:0];
            r_s1_frac <= x_val[FRAC_BITS-1:0];
            r_s1_r    <= root_step;
        end
        if (w_rdy[2]) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_q    <= q_val;
            r_s2_n    <= n_diff[POS_W-1:0];
            r_s2_frac <= r_s1_frac;
            r_s2_r    <= r_s1_r;
        end
        if (w_rdy[3]) begin
            r_s3_ch   <= r_s2_ch;
            r_s3_q    <= r_s2_q;
            r_s3_r    <= r_s2_r;
            r_s3_note <= note_norm;
            r_s3_nf   <= nf_val;
        end
        if (w_rdy[4]) begin
            r_s4_ch   <= r_s3_ch;
            r_s4_q    <= r_s3_q;
            r_s4_r    <= r_s3_r;
            r_s4_note <= r_s3_note;
            r_s4_v    <= v_val;
        end
        if (w_rdy[5]) begin
            r_s5_ch   <= r_s4_ch;
            r_s5_q    <= r_s4_q;
            r_s5_r    <= r_s4_r;
            r_s5_note <= r_s4_note;
            r_s5_idx  <= idx_val;
        end
        if (w_rdy[6]) begin
            r_s6_ch    <= r_s5_ch;
            r_s6_pitch <= pitch_sat;
        end
        if (w_rdy[7]) begin
            r_out_ch    <= r_s6_ch;
            r_out_pitch <= r_s6_pitch;
            r_out_trig  <= trig_val;
        end
    end

    // channel state advances as the request enters the output register
    always_comb begin
        trig_req.en    = r_vld[6] && w_rdy[7];
        trig_req.ch    = r_s6_ch;
        trig_req.pitch = r_s6_pitch;
    end

    sq31_trigger #(
        .CHANNELS (CHANNELS)
    ) u_trigger (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (trig_req),
        .i_pulse_len (r_pulse_len),
        .o_trigger   (trig_val)
    );

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {5'b0, r_out_trig, r_out_pitch};
    assign o_m_tuser  = r_out_ch;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SQ31_ASSERT_COMB(a_bubble_ready, r_run && !(&r_vld), o_s_tready,
        "pipeline has a free stage but refuses a request")
    `SQ31_ASSERT_NEXT(a_accept_lands, i_s_tvalid && o_s_tready, r_vld[0],
        "accepted request did not reach the input stage")
    `SQ31_ASSERT_COMB(a_neighbour_order, r_vld[2],
        (lo_step <= $signed({2'b00, r_s2_n})) && (up_step > $signed({2'b00, r_s2_n})),
        "lower and upper steps do not bracket the fraction")
    `SQ31_ASSERT_COMB(a_no_trig_bad_ch, r_vld[NSTG-1] && ({1'b0, r_out_ch} >= CH_LIMIT),
        !r_out_trig, "trigger raised for a channel without state")

endmodule

`default_nettype wire

### tb/sv/scale_quantizer_31_step_core_checker.sv
// ----------------------------------------------------------------------------
// scale_quantizer_31_step_core_checker
// watches the request, result and register write ports of the 31-step pitch
// quantizer, predicts each result from its own copy of the scale tables and
// channel state, and compares results in order, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scale_quantizer_31_step_core_checker
    import sq31_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [47:0]           i_s_tdata,   // cv_in[20:0], root_cv[41:21], zero pad
    input  wire logic [CH_W-1:0]       i_s_tuser,   // channel
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [15:0]           i_m_tdata,   // pitch_steps[9:0], trigger[10], zero pad
    input  wire logic [CH_W-1:0]       i_m_tuser,   // out_channel
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_outstanding,
    output int                         o_checked
);

    localparam longint ONE       = 64'sd1 << FRAC_BITS;
    localparam longint SPAN      = STEPS * ONE;
    localparam int     PITCH_MIN = -(1 << (PITCH_W - 1));
    localparam int     PITCH_MAX = (1 << (PITCH_W - 1)) - 1;

    typedef struct packed {
        logic [CH_W-1:0]           ch;
        logic signed [PITCH_W-1:0] pitch;
        logic                      trig;
    } t_quant_result;

    // register copies
    logic [STEPS-1:0]   mask_r;
    logic [RMODE_W-1:0] rmode_r;
    logic               equal_r;
    logic [PULSE_W-1:0] pulse_len_r;

    // channel state
    logic signed [PITCH_W-1:0] held_pitch [CHANNELS];
    logic [PULSE_W-1:0]        pulse_cnt  [CHANNELS];

    // scale tables derived from the mask
    int scale_steps [STEPS+1];
    int scale_size;
    int step_below  [STEPS];
    int step_above  [STEPS];

    t_quant_result quantized_q [$];
    int            fails   = 0;
    int            checked = 0;

    function automatic void rebuild_scale(input logic [STEPS-1:0] mask);
        int n;
        int j;
        n = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (mask[i]) begin
                scale_steps[n] = i;
                n++;
            end
        end
        // empty mask keeps the root only
        if (n == 0) begin
            n = 1;
            scale_steps[0] = 0;
        end
        scale_size     = n;
        scale_steps[n] = scale_steps[0] + STEPS;
        // without step 0 the lower neighbor starts one octave down
        j = (scale_steps[0] == 0) ? 0 : -1;
        for (int i = 0; i < STEPS; i++) begin
            if (j + 1 < n && i >= scale_steps[j+1]) begin
                j++;
            end
            step_below[i] = (j < 0) ? scale_steps[n-1] - STEPS : scale_steps[j];
            step_above[i] = scale_steps[j+1];
        end
    endfunction

    function automatic int quantize_pitch(input logic signed [IN_W-1:0] cv,
                                          input logic signed [IN_W-1:0] root);
        longint cv_l;
        longint rfrac;
        longint rstep;
        longint x;
        longint oct;
        longint f;
        longint nf;
        longint idx;
        longint lo;
        longint up;
        longint thr2;
        longint note;
        longint pitch;
        cv_l  = cv;
        rfrac = root[FRAC_BITS-1:0];
        rstep = (STEPS * rfrac + ONE / 2) >>> FRAC_BITS;
        x     = STEPS * cv_l - rstep * ONE;
        oct   = x / SPAN;
        if (x % SPAN < 0) begin
            oct--;
        end
        f = x - oct * SPAN;
        if (!equal_r) begin
            lo = step_below[int'(f >>> FRAC_BITS)];
            up = step_above[int'(f >>> FRAC_BITS)];
            if (rmode_r == RND_DOWN) begin
                thr2 = 2 * up - 1;
            end else if (rmode_r == RND_UP) begin
                thr2 = 2 * lo + 1;
            end else begin
                // nearest, also for the unused mode code
                thr2 = lo + up;
                if (!thr2[0]) begin
                    thr2++;
                end
            end
            note = (2 * f > thr2 * ONE) ? up : lo;
        end else begin
            nf = scale_size * f;
            if (rmode_r == RND_DOWN) begin
                idx = nf / SPAN;
            end else if (rmode_r == RND_UP) begin
                idx = (nf + SPAN - 1) / SPAN;
            end else begin
                idx = (2 * nf + SPAN) / (2 * SPAN);
            end
            if (idx > scale_size) begin
                idx = scale_size;
            end
            note = scale_steps[int'(idx)];
        end
        pitch = oct * STEPS + note + rstep;
        if (pitch < PITCH_MIN) begin
            pitch = PITCH_MIN;
        end
        if (pitch > PITCH_MAX) begin
            pitch = PITCH_MAX;
        end
        return int'(pitch);
    endfunction

    always @(posedge i_clk) begin : track
        t_quant_result want;
        t_quant_result fresh;
        if (!i_rst_n) begin
            mask_r      = MASK_RESET;
            rmode_r     = RND_NEAREST;
            equal_r     = 1'b0;
            pulse_len_r = PULSE_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                held_pitch[c] = '0;
                pulse_cnt[c]  = '0;
            end
            rebuild_scale(mask_r);
            quantized_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (quantized_q.size() == 0) begin
                    $error("result on channel %0d with no request outstanding", i_m_tuser);
                    fails++;
                end else begin
                    want = quantized_q.pop_front();
                    if (i_m_tuser !== want.ch) begin
                        $error("out_channel mismatch: expected %0d, actual %0d",
                               want.ch, i_m_tuser);
                        fails++;
                    end
                    if ($signed(i_m_tdata[PITCH_W-1:0]) !== want.pitch) begin
                        $error("pitch_steps mismatch: expected %0d, actual %0d",
                               want.pitch, $signed(i_m_tdata[PITCH_W-1:0]));
                        fails++;
                    end
                    if (i_m_tdata[PITCH_W] !== want.trig) begin
                        $error("trigger mismatch: expected %0d, actual %0d",
                               want.trig, i_m_tdata[PITCH_W]);
                        fails++;
                    end
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh.ch    = i_s_tuser;
                fresh.pitch = PITCH_W'(quantize_pitch($signed(i_s_tdata[IN_W-1:0]),
                                                      $signed(i_s_tdata[2*IN_W-1:IN_W])));
                fresh.trig  = 1'b0;
                if (fresh.ch < CHANNELS) begin
                    // a change restarts the pulse unless more of it is left
                    if (fresh.pitch != held_pitch[fresh.ch]) begin
                        if (pulse_cnt[fresh.ch] < pulse_len_r) begin
                            pulse_cnt[fresh.ch] = pulse_len_r;
                        end
                        held_pitch[fresh.ch] = fresh.pitch;
                    end
                    if (pulse_cnt[fresh.ch] != 0) begin
                        fresh.trig = 1'b1;
                        pulse_cnt[fresh.ch]--;
                    end
                end
                quantized_q.push_back(fresh);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_NOTE_MASK: begin
                        mask_r = i_cfg_data[STEPS-1:0];
                        rebuild_scale(mask_r);
                    end
                    REG_ROUND_MODE: begin
                        rmode_r = i_cfg_data[RMODE_W-1:0];
                    end
                    REG_EQUAL_SHARE: begin
                        equal_r = i_cfg_data[0];
                    end
                    default: begin
                        pulse_len_r = i_cfg_data[PULSE_W-1:0];
                    end
                endcase
            end
        end
        o_outstanding <= quantized_q.size();
        o_fail_count  <= fails;
        o_checked     <= checked;
    end

endmodule

### tb/sv/scale_quantizer_31_step_core_tb.sv
// ----------------------------------------------------------------------------
// scale_quantizer_31_step_core_tb
// drives the 31-step pitch quantizer with directed edge values and then with
// held notes, boundary values and noise under many register settings, with
// random bursts on the request side and random stalls on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scale_quantizer_31_step_core_tb;
    import sq31_pkg::*;

    localparam int CHANNELS     = 16;
    localparam int NUM_SETUPS   = 16;
    localparam int SETUP_ITEMS  = 125;
    localparam int STEADY_ITEMS = 40;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 16;
    localparam int S_DATA_W     = 48;

    localparam logic [RMODE_W-1:0]     RND_SPARE = 2'd3;
    localparam logic signed [IN_W-1:0] CV_TOP    = 21'sd655360;
    localparam logic signed [IN_W-1:0] CV_BOTTOM = -21'sd655360;
    localparam logic signed [IN_W-1:0] FIELD_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] FIELD_MIN = {1'b1, {(IN_W-1){1'b0}}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [CH_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [CH_W-1:0]       m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   outstanding;
    int   checked;
    int   sent        = 0;
    int   burst_left  = 0;
    int   idle_cycles = 0;
    logic tx_live     = 1'b0;
    logic tx_steady   = 1'b0;
    logic rx_hold_req = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    scale_quantizer_31_step_core #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    scale_quantizer_31_step_core_checker #(
        .CHANNELS(CHANNELS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_checked    (checked)
    );

    // drop valid once the last request has gone through
    task automatic idle_sender();
        if (tx_live) begin
            s_tvalid <= 1'b0;
            tx_live = 1'b0;
        end
    endtask

    task automatic send_item(input logic [CH_W-1:0] ch, input logic signed [IN_W-1:0] cv,
                             input logic signed [IN_W-1:0] root);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0 || tx_steady) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                idle_sender();
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-2*IN_W){1'b0}}, root, cv};
        s_tuser  <= ch;
        do @(posedge clk); while (!s_tready);
        tx_live = 1'b1;
        sent++;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: stretches of steady, sparse, dense and periodic ready
    initial begin : rx_stall
        int stretch;
        int style;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(10, 150);
            for (int k = 0; k < stretch && !rx_hold_req; k++) begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((k / 5) % 2 == 0);
                endcase
                @(posedge clk);
            end
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no request moved for %0d cycles, %0d results outstanding",
                     idle_cycles, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [IN_W-1:0] held_cv [CHANNELS];
        logic signed [IN_W-1:0] root_of [CHANNELS];
        logic [STEPS-1:0]       mask;
        logic [RMODE_W-1:0]     rmode;
        logic [PULSE_W-1:0]     pulse;
        logic [CH_W-1:0]        ch;
        logic signed [IN_W-1:0] cv;
        logic signed [IN_W-1:0] root;
        int                     ch_span;
        int                     pick;
        int                     hstep;
        for (int c = 0; c < CHANNELS; c++) begin
            held_cv[c] = '0;
            root_of[c] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge values under the reset scale
        send_item(4'd0, '0, '0);
        send_item(4'd1, CV_TOP, '0);
        send_item(4'd2, CV_BOTTOM, '0);
        send_item(4'd3, FIELD_MAX, FIELD_MAX);
        send_item(4'd4, FIELD_MIN, FIELD_MIN);
        send_item(4'd5, FIELD_MIN, FIELD_MAX);
        send_item(4'd6, '0, 21'sh00421);
        send_item(4'd6, '0, 21'sh00422);
        send_item(4'd7, '0, 21'sh0FFFF);
        send_item(4'd7, '0, 21'sh08000);
        send_item(4'd8, 21'sd1057, '0);
        send_item(4'd8, 21'sd1058, '0);
        send_item(4'd9, -21'sd1, '0);
        send_item(4'd9, -21'sd1, -21'sd1);
        send_item(4'd15, CV_TOP, CV_BOTTOM);
        repeat (5) send_item(4'd1, CV_TOP, '0);
        send_item(4'd0, '0, '0);

        for (int setup = 0; setup < NUM_SETUPS; setup++) begin
            case (setup % 6)
                0: mask = '0;
                1: mask = '1;
                2: mask = 31'h4000_0000;
                3: mask = $urandom;
                4: mask = $urandom & ~31'h1;
                default: mask = MASK_RESET;
            endcase
            case (setup % 4)
                0: rmode = RND_DOWN;
                1: rmode = RND_NEAREST;
                2: rmode = RND_UP;
                default: rmode = RND_SPARE;
            endcase
            case (setup % 5)
                0: pulse = '0;
                1: pulse = 16'd1;
                2: pulse = '1;
                3: pulse = $urandom_range(2, 100);
                default: pulse = PULSE_RESET;
            endcase
            ch_span = (setup % 3 == 0) ? 1 : (setup % 3 == 1) ? 3 : CHANNELS;

            idle_sender();
            wait_drained();
            write_reg(REG_NOTE_MASK, mask);
            write_reg(REG_ROUND_MODE, CFG_DATA_W'(rmode));
            write_reg(REG_EQUAL_SHARE, CFG_DATA_W'((setup / 4) % 2));
            write_reg(REG_PULSE_LEN, CFG_DATA_W'(pulse));

            // one long result stall while requests keep coming
            if (setup == 2) begin
                rx_hold_req = 1'b1;
                tx_steady   = 1'b1;
            end
            for (int k = 0; k < SETUP_ITEMS; k++) begin
                if (k == STEADY_ITEMS) begin
                    tx_steady = 1'b0;
                end
                ch   = $urandom_range(0, ch_span - 1);
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // held note with a little jitter
                    cv = held_cv[ch] + (int'($urandom_range(0, 400)) - 200);
                end else if (pick < 70) begin
                    cv = int'($urandom_range(0, 1310720)) - 655360;
                end else if (pick < 80) begin
                    cv = $urandom;
                end else begin
                    // close to a half-step boundary
                    hstep = int'($urandom_range(0, 1240)) - 620;
                    cv = (hstep * 32768) / 31 + (int'($urandom_range(0, 4)) - 2);
                end
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    root = root_of[ch];
                end else if (pick < 95) begin
                    root_of[ch] = int'($urandom_range(0, 1310720)) - 655360;
                    root = root_of[ch];
                end else begin
                    root = $urandom;
                end
                held_cv[ch] = cv;
                send_item(ch, cv, root);
            end
        end

        idle_sender();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d requests over %0d register settings, %0d results checked",
                 sent, NUM_SETUPS + 1, checked);
        $display("all round modes with and without equal share, empty and full masks, pulse 0..65535");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sq31_pkg.sv
rtl/core/sq31_mask_info.sv
rtl/core/sq31_trigger.sv
rtl/core/scale_quantizer_31_step_core.sv
tb/sv/scale_quantizer_31_step_core_checker.sv
tb/sv/scale_quantizer_31_step_core_tb.sv
